// ----- hw/rtl/lzsswd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzsswd_pkg
// Shared constants, types and helpers for the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzsswd_pkg;

  // History window geometry
  localparam int WINDOW_BITS = 12;
  localparam int WIN_DEPTH   = 1 << WINDOW_BITS;

  // Produced-byte counter and output limit
  localparam int COUNT_W = 25;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(25'h100_0000);

  // Compressed stream item widths
  localparam int BYTE_W  = 8;
  localparam int FLAGS_W = 9;
  localparam int REM_W   = 5;   // copy bytes left after the current one, 0..16

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // latch input item, clear stream state on start
    logic load_flags;  // take the byte as a new flag byte
    logic hold_high;   // keep the byte as reference high byte
    logic start_copy;  // set up read pointer and length of a reference
    logic rd_issue;    // read the window at the copy pointer
    logic emit_lit;    // send the literal and write it to the window
    logic emit_copy;   // send the copied byte and write it to the window
    logic token_done;  // consume one flag decision
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ref_phase;   // expecting the low byte of a reference
    logic flags_empty; // no flag decisions left
    logic flag_lit;    // current decision is a literal
    logic over_limit;  // produced count has reached the limit
    logic hit_limit;   // next emitted byte reaches the limit
    logic copy_last;   // current copy byte is the final one
    logic out_free;    // output register can take a byte
  } dp_status_t;

  // Window position of a reference: high byte and upper nibble of low byte
  function automatic logic [WINDOW_BITS-1:0] win_pos(input logic [BYTE_W-1:0] high_b,
                                                     input logic [BYTE_W-1:0] low_b);
    logic [31:0] word;
    begin
      word = {20'd0, high_b, low_b[7:4]};
      win_pos = word[WINDOW_BITS-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/lzss_window_decoder_top.sv -----
// ----------------------------------------------------------------------------
// lzss_window_decoder_top
// LZSS stream decoder with a 4 KiB history window and an output byte limit.
// ----------------------------------------------------------------------------
// Input stream: one compressed byte per item on in_tdata, with in_tuser set
// on the first byte of a new stream (clears pointer, flags and count; the
// window reads as zero until rewritten). Output stream: one decoded byte per
// item; out_tlast marks the final byte caused by an input item and out_tuser
// marks the byte that completes the configured length. cfg_data sets the
// output limit and may be written while the block is idle.
// Sequencing: a flag byte or a reference high byte passes through S_IDLE
// and S_DECODE, a literal also through S_LIT, and a reference through
// S_IDLE, S_DECODE and one S_RD, S_WR pair per copied byte (at most 17),
// each read from the window RAM's registered port and written back into
// the window. Literal output is registered in S_LIT, copy output in S_WR.
// Reset sets the limit to 16777216 and starts a new stream; no clearing pass
// of the window is needed. When the receiver stalls, the output register
// holds its byte and decoding waits at the next byte to emit; flag and
// high bytes are still taken while a result is waiting.
// ----------------------------------------------------------------------------
module lzss_window_decoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [7:0] data_byte
  input  logic [7:0]                      in_tdata,
  // in_tuser: [0] stream_start
  input  logic [0:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: [7:0] out_byte
  output logic [7:0]                      out_tdata,
  // out_tuser: [0] limit_reached
  output logic [0:0]                      out_tuser,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [lzsswd_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);

  lzsswd_pkg::dp_cmd_t    cmd;
  lzsswd_pkg::dp_status_t status;

  // Limit register is always writable
  assign cfg_ready = 1'b1;

  lzsswd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lzsswd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (in_tdata),
    .in_start  (in_tuser[0]),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_limit (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_limit (out_tuser[0])
  );

endmodule

// ----- hw/rtl/lzsswd_ram.sv -----
// ----------------------------------------------------------------------------
// lzsswd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzsswd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/lzsswd_datapath.sv -----
// ----------------------------------------------------------------------------
// lzsswd_datapath
// Stream state, history window, copy pointer, produced count and the output
// register of the LZSS window decoder.
// ----------------------------------------------------------------------------
module lzsswd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lzsswd_pkg::dp_cmd_t              cmd,
  output lzsswd_pkg::dp_status_t           status,
  input  logic [lzsswd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                             in_start,
  input  logic                             cfg_wr,
  input  logic [lzsswd_pkg::COUNT_W-1:0]   cfg_limit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lzsswd_pkg::BYTE_W-1:0]    out_byte,
  output logic                             out_last,
  output logic                             out_limit
);

  localparam int WB = lzsswd_pkg::WINDOW_BITS;
  localparam int CW = lzsswd_pkg::COUNT_W;
  localparam int BW = lzsswd_pkg::BYTE_W;
  localparam int FW = lzsswd_pkg::FLAGS_W;
  localparam int RW = lzsswd_pkg::REM_W;

  logic [CW-1:0] limit_r,   limit_nxt;
  logic [BW-1:0] byte_r,    byte_nxt;
  logic [FW-1:0] flags_r,   flags_nxt;
  logic          phase_r,   phase_nxt;
  logic [BW-1:0] held_r,    held_nxt;
  logic [WB-1:0] wp_r,      wp_nxt;
  logic [CW-1:0] count_r,   count_nxt;
  logic [WB-1:0] rd_ptr_r,  rd_ptr_nxt;
  logic [RW-1:0] rem_r,     rem_nxt;
  logic          rd_ok_r,   rd_ok_nxt;
  logic          ovalid_r,  ovalid_nxt;
  logic [BW-1:0] obyte_r,   obyte_nxt;
  logic          olast_r,   olast_nxt;
  logic          olim_r,    olim_nxt;

  logic [CW-1:0] count_inc;
  logic [WB-1:0] rd_off;
  logic          rd_written;
  logic [BW-1:0] ram_rd_data;
  logic [BW-1:0] emit_byte;
  logic          emit_any;

  // Window entries written since stream start form a run from address 1
  assign count_inc  = count_r + CW'(1);
  assign rd_off     = rd_ptr_r - WB'(1);
  assign rd_written = (|count_r[CW-1:WB]) || (rd_off < count_r[WB-1:0]);

  assign emit_any  = cmd.emit_lit | cmd.emit_copy;
  assign emit_byte = cmd.emit_lit ? byte_r : (rd_ok_r ? ram_rd_data : '0);

  // Status toward the controller
  assign status.ref_phase   = phase_r;
  assign status.flags_empty = ~|flags_r[FW-1:1];
  assign status.flag_lit    = flags_r[0];
  assign status.over_limit  = count_r >= limit_r;
  assign status.hit_limit   = count_inc == limit_r;
  assign status.copy_last   = rem_r == '0;
  assign status.out_free    = ~ovalid_r | out_ready;

  // Next-state logic
  always_comb begin
    limit_nxt  = limit_r;
    byte_nxt   = byte_r;
    flags_nxt  = flags_r;
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    wp_nxt     = wp_r;
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    rem_nxt    = rem_r;
    rd_ok_nxt  = rd_ok_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    olim_nxt   = olim_r;

    if (cfg_wr) begin
      limit_nxt = cfg_limit;
    end

    // Latch item; a stream start clears all stream state
    if (cmd.accept) begin
      byte_nxt = in_byte;
      if (in_start) begin
        flags_nxt = '0;
        phase_nxt = 1'b0;
        held_nxt  = '0;
        wp_nxt    = WB'(1);
        count_nxt = '0;
      end
    end

    if (cmd.load_flags) begin
      flags_nxt = {1'b1, byte_r};
    end

    if (cmd.hold_high) begin
      held_nxt  = byte_r;
      phase_nxt = 1'b1;
    end

    if (cmd.start_copy) begin
      rd_ptr_nxt = lzsswd_pkg::win_pos(held_r, byte_r);
      rem_nxt    = RW'(byte_r[3:0]) + RW'(1);
      phase_nxt  = 1'b0;
    end

    if (cmd.rd_issue) begin
      rd_ok_nxt = rd_written;
    end

    // Emit one byte: output register, window write, count
    if (emit_any) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = emit_byte;
      olim_nxt   = status.hit_limit;
      olast_nxt  = cmd.emit_lit | status.copy_last | status.hit_limit;
      wp_nxt     = wp_r + WB'(1);
      count_nxt  = count_inc;
    end

    if (cmd.emit_copy) begin
      rd_ptr_nxt = rd_ptr_r + WB'(1);
      rem_nxt    = rem_r - RW'(1);
    end

    if (cmd.token_done) begin
      flags_nxt = {1'b0, flags_r[FW-1:1]};
      phase_nxt = 1'b0;
    end
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= lzsswd_pkg::LIMIT_RESET;
      flags_r  <= '0;
      phase_r  <= 1'b0;
      held_r   <= '0;
      wp_r     <= WB'(1);
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      limit_r  <= limit_nxt;
      flags_r  <= flags_nxt;
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      wp_r     <= wp_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    rem_r    <= rem_nxt;
    rd_ok_r  <= rd_ok_nxt;
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
    olim_r   <= olim_nxt;
  end

  // History window
  lzsswd_ram #(
    .WIDTH (BW),
    .DEPTH (lzsswd_pkg::WIN_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (emit_any),
    .wr_addr (wp_r),
    .wr_data (emit_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rd_data)
  );

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_limit = olim_r;

endmodule

// ----- hw/rtl/lzsswd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzsswd_ctrl
// Token sequencer of the LZSS window decoder: decodes each item and steps
// reference copies one window read at a time.
// ----------------------------------------------------------------------------
module lzsswd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lzsswd_pkg::dp_status_t status,
  output lzsswd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LIT,
    S_RD,
    S_WR
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.ref_phase) begin
          cmd.start_copy = 1'b1;
          state_nxt      = S_RD;
        end else if (status.flags_empty) begin
          cmd.load_flags = 1'b1;
          state_nxt      = S_IDLE;
        end else if (status.flag_lit) begin
          state_nxt = S_LIT;
        end else begin
          cmd.hold_high = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LIT: begin
        // Drop the literal once the limit is met
        if (status.over_limit) begin
          cmd.token_done = 1'b1;
          state_nxt      = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit_lit   = 1'b1;
          cmd.token_done = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RD: begin
        if (status.over_limit) begin
          cmd.token_done = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_WR;
        end
      end
      S_WR: begin
        if (status.out_free) begin
          cmd.emit_copy = 1'b1;
          if (status.copy_last || status.hit_limit) begin
            cmd.token_done = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/lzsswd_checker.sv -----
// ----------------------------------------------------------------------------
// lzsswd_checker
// Port-level checks of the LZSS window decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzsswd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast,
  input logic       out_tvalid,
  input logic       out_tready
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output item changed");

  // The byte that completes the limit ends the run of its input item
  a_limit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("limit byte without tlast");

  // An accepted item is decoded before the next one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in back-to-back cycles");

endmodule

bind lzss_window_decoder_top lzsswd_checker u_lzsswd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
